FILE: hdl/kmsd_pkg.sv
// Shared types and field widths for the key matrix sample debounce block.
// Used by kmsd_history and key_matrix_sample_debounce; no dependencies.
package kmsd_pkg;

    localparam int ROW_W = 3;
    localparam int KEY_W = 16;

    typedef struct packed {
        logic [ROW_W-1:0] row_index;
        logic [KEY_W-1:0] column_levels;
    } t_row_req;

    typedef struct packed {
        logic [ROW_W-1:0] result_row;
        logic [KEY_W-1:0] debounced_keys;
    } t_row_res;

endpackage

FILE: hdl/key_matrix_sample_debounce.sv
// Top level of the key matrix sample debounce block: request and result registers.
// Depends on kmsd_pkg and kmsd_history.
// Pipeline: an accepted request is registered in the input stage, and its result in the output stage.
// Throughput: one request per cycle while i_out_stall is low, limited by the single history update per cycle.
// Reset (synchronous, active low) clears all run counters, both pipeline valids
// and the polarity register (active-low columns).
module key_matrix_sample_debounce import kmsd_pkg::*; #(
    parameter int ROWS    = 8,
    parameter int COLS    = 16,
    parameter int SAMPLES = 4
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_stall,
    input  t_row_req i_in_req,
    output logic     o_out_valid,
    input  logic     i_out_stall,
    output t_row_res o_out_res,
    input  logic     i_cfg_valid,
    output logic     o_cfg_ready,
    input  logic     i_cfg_data
);

    localparam logic [KEY_W-1:0] COL_MASK =
        (COLS >= KEY_W) ? {KEY_W{1'b1}} : KEY_W'((32'd1 << COLS) - 32'd1);

    logic             r_active_high;
    logic             r_s1_valid;
    logic [ROW_W-1:0] r_s1_row;
    logic [KEY_W-1:0] r_s1_pressed;
    logic             r_s2_valid;
    t_row_res         r_s2_res;
    logic             w_adv2;
    logic             w_adv1;
    logic             w_in_acc;
    logic [KEY_W-1:0] w_pressed;
    logic [KEY_W-1:0] w_keys;

    assign w_adv2      = !r_s2_valid || !i_out_stall;
    assign w_adv1      = !r_s1_valid || w_adv2;
    assign o_in_stall  = !w_adv1;
    assign w_in_acc    = i_in_valid && w_adv1;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_s2_valid;
    assign o_out_res   = r_s2_res;

    assign w_pressed = (r_active_high ? i_in_req.column_levels
                                      : ~i_in_req.column_levels) & COL_MASK;

    kmsd_history #(
        .ROWS    (ROWS),
        .SAMPLES (SAMPLES)
    ) u_history (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_update  (r_s1_valid && w_adv2),
        .i_row     (r_s1_row),
        .i_pressed (r_s1_pressed),
        .o_keys    (w_keys)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active_high <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_active_high <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            if (w_adv1) begin
                r_s1_valid <= i_in_valid;
            end
            if (w_adv2) begin
                r_s2_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_s1_row     <= i_in_req.row_index;
            r_s1_pressed <= w_pressed;
        end
        if (w_adv2 && r_s1_valid) begin
            r_s2_res.result_row     <= r_s1_row;
            r_s2_res.debounced_keys <= w_keys;
        end
    end

    a_accept_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> r_s1_valid)
        else $error("accepted request not held in input stage");

    a_col_mask: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s2_valid |-> ((r_s2_res.debounced_keys & ~COL_MASK) == '0))
        else $error("debounced key beyond last column");

    a_cfg_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg_valid && o_cfg_ready) |=> (r_active_high == $past(i_cfg_data)))
        else $error("polarity register not written");

endmodule

FILE: hdl/kmsd_history.sv
// Per-row, per-column run counters of consecutive pressed samples.
// Depends on kmsd_pkg; a key debounces as pressed once its run reaches SAMPLES.
module kmsd_history import kmsd_pkg::*; #(
    parameter int ROWS    = 8,
    parameter int SAMPLES = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_update,
    input  logic [ROW_W-1:0] i_row,
    input  logic [KEY_W-1:0] i_pressed,
    output logic [KEY_W-1:0] o_keys
);

    localparam int RIDX_W = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int CNT_W  = $clog2(SAMPLES + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(SAMPLES);

    logic [CNT_W-1:0]  r_cnt [ROWS][KEY_W];
    logic [CNT_W-1:0]  n_cnt [KEY_W];
    logic [31:0]       w_row_ext;
    logic              w_hit;
    logic [RIDX_W-1:0] w_idx;

    always_comb begin
        w_row_ext = 32'(i_row);
        w_hit     = (w_row_ext < 32'(ROWS));
        w_idx     = w_hit ? w_row_ext[RIDX_W-1:0] : '0;
        for (int c = 0; c < KEY_W; c++) begin
            if (!i_pressed[c]) begin
                n_cnt[c] = '0;
            end else if (r_cnt[w_idx][c] == CNT_MAX) begin
                n_cnt[c] = CNT_MAX;
            end else begin
                n_cnt[c] = CNT_W'(r_cnt[w_idx][c] + 1'b1);
            end
            o_keys[c] = w_hit && (n_cnt[c] == CNT_MAX);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < ROWS; r++) begin
                for (int c = 0; c < KEY_W; c++) begin
                    r_cnt[r][c] <= '0;
                end
            end
        end else if (i_update && w_hit) begin
            r_cnt[w_idx] <= n_cnt;
        end
    end

    a_release_now: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_update |-> ((o_keys & ~i_pressed) == '0))
        else $error("debounced key set without a pressed sample");

    a_bad_row_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_hit |-> (o_keys == '0))
        else $error("row outside matrix gave pressed keys");

endmodule
